// File: rtl/ssc_pkg.sv
package ssc_pkg;

    // Default coordinate width and fixed field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int TENSION_W      = 8;
    localparam int SHARE_W        = 24;   // Q0.24 share of tension

    localparam logic [TENSION_W-1:0] TENSION_RST = 8'd128;

    // Pen event kinds
    localparam logic [1:0] REQ_DOWN = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_UP   = 2'd2;

    // Result kinds
    localparam logic RES_CURVE = 1'b0;
    localparam logic RES_DOT   = 1'b1;

endpackage

// File: rtl/ssc_isqrt.sv
module ssc_isqrt #(
    parameter int RW = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_value,
    output logic            o_busy,
    output logic [RW-1:0]   o_root
);

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] r_val;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;

    logic [RW+3:0] rem2;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // One root bit per cycle: bring down two radicand bits, try the subtract
    always_comb begin
        rem2  = {r_rem, r_val[2*RW-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        ge    = (rem2 >= trial);
        diff  = rem2 - trial;
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(RW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Radicand shift register, remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_val  <= {r_val[2*RW-3:0], 2'b00};
            r_rem  <= ge ? diff[RW+1:0] : rem2[RW+1:0];
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

endmodule

// File: rtl/ssc_div.sv
module ssc_div #(
    parameter int DW = 19,
    parameter int QW = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic             o_busy,
    output logic [QW-1:0]    o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_lo;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;

    logic [DW:0] rem2;
    logic [DW:0] diff;
    logic        ge;

    // One quotient bit per cycle; the upper numerator bits start below the divisor
    always_comb begin
        rem2 = {r_rem, r_lo[QW-1]};
        ge   = (rem2 >= {1'b0, r_den});
        diff = rem2 - {1'b0, r_den};
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Partial remainder, dividend shift register and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DW+QW-1:QW];
            r_lo  <= i_num[QW-1:0];
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DW-1:0] : rem2[DW-1:0];
            r_lo  <= {r_lo[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

endmodule

// File: rtl/stroke_spline_control_points_unit.sv
// Pen stroke to cubic Bezier segments. Down, move and up words are taken one
// at a time. A down, a buffering move, a trailing up or an unused kind gives
// no result; an up with no move before it in the stroke gives a dot marker. A move
// that completes three points runs through the accept step, two square roots on
// the shared bit-serial root unit (each with operand setup), a step to sum the
// distances, then, unless both distances are zero, two bit-serial divides for
// the tension shares and four multiply/round steps, and the emit step. The next
// word is taken while a finished result still waits on the output register.
// Write tension only while idle.
module stroke_spline_control_points_unit
    import ssc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_req_type,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_kind,
    output logic signed [COORD_BITS-1:0] o_ctrl1_x,
    output logic signed [COORD_BITS-1:0] o_ctrl1_y,
    output logic signed [COORD_BITS-1:0] o_ctrl2_x,
    output logic signed [COORD_BITS-1:0] o_ctrl2_y,
    output logic signed [COORD_BITS-1:0] o_end_x,
    output logic signed [COORD_BITS-1:0] o_end_y,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [TENSION_W-1:0]         i_cfg_tension
);

    localparam int CB = COORD_BITS;
    localparam int DS = (CB > 30) ? CB - 30 : 0;
    localparam int MW = CB + 1 - DS;       // shifted magnitude
    localparam int SW = 2 * MW + 1;        // sum of squares
    localparam int RW = MW + 1;            // root
    localparam int DW = RW + 1;            // sum of distances
    localparam int NW = DW + SHARE_W;      // divide numerator
    localparam int PW = SHARE_W + CB + 1;  // offset product
    localparam int VW = CB + 3;            // control point before saturation

    localparam logic signed [VW-1:0] SAT_HI = {{4{1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO = {{4{1'b1}}, {(CB-1){1'b0}}};

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ0  = 4'd1;
    localparam logic [3:0] ST_SQ1  = 4'd2;
    localparam logic [3:0] ST_RGO  = 4'd3;
    localparam logic [3:0] ST_ROOT = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_DGO  = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_MUL  = 4'd8;
    localparam logic [3:0] ST_ADD  = 4'd9;
    localparam logic [3:0] ST_EMIT = 4'd10;

    logic [3:0] r_state, n_state;

    logic [TENSION_W-1:0] r_tension;
    logic [1:0]           r_cnt;
    logic                 r_moved;
    logic                 r_pair;
    logic [1:0]           r_idx;

    logic signed [CB-1:0] r_bx [2];
    logic signed [CB-1:0] r_by [2];
    logic signed [CB-1:0] r_px, r_py;
    logic [SW-1:0]        r_acc;
    logic [RW-1:0]        r_d01, r_d12;
    logic [DW-1:0]        r_sum;
    logic [SHARE_W-1:0]   r_fa, r_fb;
    logic [PW-1:0]        r_prod;
    logic                 r_wneg;
    logic                 r_res_kind;
    logic signed [CB-1:0] r_res_c [4];

    logic                 r_ovalid;
    logic                 r_okind;
    logic signed [CB-1:0] r_oc [4];
    logic signed [CB-1:0] r_oex, r_oey;

    logic in_acc;
    logic emit_go;

    // Distance operand selection and squaring
    logic signed [CB-1:0] ax, ay, bx, by;
    logic [CB:0]          dx, dy, dmag_x, dmag_y;
    logic [MW-1:0]        sq_op;
    logic [2*MW-1:0]      sq_prod;

    // Share, offset and control point arithmetic
    logic [TENSION_W+RW-1:0] td;
    logic [NW-1:0]           div_num;
    logic [CB:0]             wx, wy, w_sel, w_mag;
    logic [SHARE_W-1:0]      f_sel;
    logic [PW:0]             rnd;
    logic [CB+1:0]           m;
    logic signed [CB-1:0]    x1_sel;
    logic signed [VW-1:0]    cval;
    logic                    do_sub;
    logic signed [CB-1:0]    csat;

    logic          sq_start, sq_busy;
    logic [RW-1:0] sq_root;
    logic          dv_start, dv_busy;
    logic [SHARE_W-1:0] dv_quot;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign emit_go = (r_state == ST_EMIT) && (!r_ovalid || !i_out_stall);

    always_comb begin
        ax = r_pair ? r_bx[1] : r_bx[0];
        ay = r_pair ? r_by[1] : r_by[0];
        bx = r_pair ? r_px : r_bx[1];
        by = r_pair ? r_py : r_by[1];
        dx = {bx[CB-1], bx} - {ax[CB-1], ax};
        dy = {by[CB-1], by} - {ay[CB-1], ay};
        dmag_x = dx[CB] ? (~dx + 1'b1) : dx;
        dmag_y = dy[CB] ? (~dy + 1'b1) : dy;
        sq_op   = (r_state == ST_SQ1) ? dmag_y[CB:DS] : dmag_x[CB:DS];
        sq_prod = sq_op * sq_op;
    end

    always_comb begin
        td      = r_tension * (r_pair ? r_d12 : r_d01);
        div_num = {1'b0, td, 16'b0} + NW'(r_sum[DW-1:1]);

        wx     = {r_px[CB-1], r_px} - {r_bx[0][CB-1], r_bx[0]};
        wy     = {r_py[CB-1], r_py} - {r_by[0][CB-1], r_by[0]};
        w_sel  = r_idx[0] ? wy : wx;
        w_mag  = w_sel[CB] ? (~w_sel + 1'b1) : w_sel;
        f_sel  = r_idx[1] ? r_fb : r_fa;

        rnd    = {1'b0, r_prod} + ((PW+1)'(1) << (SHARE_W - 1));
        m      = rnd[PW:SHARE_W];
        x1_sel = r_idx[0] ? r_by[1] : r_bx[1];
        do_sub = r_idx[1] ? r_wneg : !r_wneg;
        cval   = do_sub ? ({{3{x1_sel[CB-1]}}, x1_sel} - {1'b0, m})
                        : ({{3{x1_sel[CB-1]}}, x1_sel} + {1'b0, m});
        if (cval > SAT_HI) begin
            csat = SAT_HI[CB-1:0];
        end else if (cval < SAT_LO) begin
            csat = SAT_LO[CB-1:0];
        end else begin
            csat = cval[CB-1:0];
        end
    end

    assign sq_start = (r_state == ST_RGO);
    assign dv_start = (r_state == ST_DGO);

    ssc_isqrt #(.RW(RW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value ({1'b0, r_acc}),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    ssc_div #(.DW(DW), .QW(SHARE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_busy  (dv_busy),
        .o_quot  (dv_quot)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_MOVE && r_cnt[1]) begin
                        n_state = ST_SQ0;
                    end else if (i_req_type == REQ_UP && !r_moved) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SQ0:  n_state = ST_SQ1;
            ST_SQ1:  n_state = ST_RGO;
            ST_RGO:  n_state = ST_ROOT;
            ST_ROOT: begin
                if (!sq_busy) begin
                    n_state = r_pair ? ST_SUM : ST_SQ0;
                end
            end
            ST_SUM:  n_state = (r_d01 == '0 && r_d12 == '0) ? ST_EMIT : ST_DGO;
            ST_DGO:  n_state = ST_DIV;
            ST_DIV: begin
                if (!dv_busy) begin
                    n_state = r_pair ? ST_MUL : ST_DGO;
                end
            end
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = (r_idx == 2'd3) ? ST_EMIT : ST_MUL;
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state: sequencer, stroke bookkeeping, tension, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_moved   <= 1'b0;
            r_tension <= TENSION_RST;
            r_ovalid  <= 1'b0;
            r_pair    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tension <= i_cfg_tension;
            end
            if (in_acc) begin
                r_pair <= 1'b0;
                r_idx  <= '0;
                unique case (i_req_type)
                    REQ_DOWN: begin
                        r_cnt   <= 2'd1;
                        r_moved <= 1'b0;
                    end
                    REQ_MOVE: begin
                        r_moved <= 1'b1;
                        r_cnt   <= r_cnt[1] ? 2'd0 : r_cnt + 1'b1;
                    end
                    REQ_UP: begin
                        r_cnt   <= 2'd0;
                        r_moved <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if ((r_state == ST_ROOT && !sq_busy) || (r_state == ST_DIV && !dv_busy)) begin
                r_pair <= !r_pair;
            end
            if (r_state == ST_ADD) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            if (i_req_type == REQ_DOWN) begin
                r_bx[0] <= i_point_x;
                r_by[0] <= i_point_y;
            end else if (i_req_type == REQ_MOVE && !r_cnt[1]) begin
                r_bx[r_cnt[0]] <= i_point_x;
                r_by[r_cnt[0]] <= i_point_y;
            end
            r_res_kind <= (i_req_type == REQ_UP) ? RES_DOT : RES_CURVE;
            for (int k = 0; k < 4; k++) begin
                r_res_c[k] <= '0;
            end
        end
        // accumulate squares of the distance components
        if (r_state == ST_SQ0) begin
            r_acc <= SW'(sq_prod);
        end
        if (r_state == ST_SQ1) begin
            r_acc <= r_acc + SW'(sq_prod);
        end
        if (r_state == ST_ROOT && !sq_busy) begin
            if (r_pair) begin
                r_d12 <= sq_root;
            end else begin
                r_d01 <= sq_root;
            end
        end
        if (r_state == ST_SUM) begin
            r_sum      <= {1'b0, r_d01} + {1'b0, r_d12};
            r_res_c[0] <= r_bx[1];
            r_res_c[1] <= r_by[1];
            r_res_c[2] <= r_bx[1];
            r_res_c[3] <= r_by[1];
        end
        if (r_state == ST_DIV && !dv_busy) begin
            if (r_pair) begin
                r_fb <= dv_quot;
            end else begin
                r_fa <= dv_quot;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= f_sel * w_mag;
            r_wneg <= w_sel[CB];
        end
        if (r_state == ST_ADD) begin
            r_res_c[r_idx] <= csat;
        end
        // hand the finished word to the output register
        if (emit_go) begin
            r_okind <= r_res_kind;
            r_oex   <= r_px;
            r_oey   <= r_py;
            for (int k = 0; k < 4; k++) begin
                r_oc[k] <= r_res_c[k];
            end
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_ctrl1_x     = r_oc[0];
    assign o_ctrl1_y     = r_oc[1];
    assign o_ctrl2_x     = r_oc[2];
    assign o_ctrl2_y     = r_oc[3];
    assign o_end_x       = r_oex;
    assign o_end_y       = r_oey;

`ifndef ASSERT_OFF
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!sq_busy && !dv_busy))
        else $error("arithmetic unit busy while sequencer idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("point count out of range");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> o_out_valid)
        else $error("emitted word not presented");
`endif

endmodule

// File: tb/sv/stroke_spline_control_points_unit_tb.sv
module stroke_spline_control_points_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int MAX_CYCLES = 400000;
    localparam int SETTLE = 150;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        logic   kind;
        t_coord c1x;
        t_coord c1y;
        t_coord c2x;
        t_coord c2y;
        t_coord ex;
        t_coord ey;
    } t_seg_word;

    // Pen-stroke predictor with its own copy of the stroke state
    class t_stroke_scoreboard;
        logic [7:0] tension_q;
        longint     pts_x[2];
        longint     pts_y[2];
        int         held;
        bit         moved;
        t_seg_word  pending[$];
        int         mismatches;
        int         segments;
        int         dots;

        function new();
            tension_q = TENSION_RST;
            held = 0;
            moved = 0;
            mismatches = 0;
            segments = 0;
            dots = 0;
        endfunction

        function longint sat(longint v);
            longint hi;
            hi = (longint'(1) << (CB - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint root_floor(longint n);
            longint r;
            longint b;
            r = 0;
            b = longint'(1) << 60;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint point_dist(longint ax, longint ay, longint bx, longint by);
            longint mx;
            longint my;
            mx = mag(bx - ax);
            my = mag(by - ay);
            return root_floor(mx * mx + my * my);
        endfunction

        // round(f*|delta|/2^24) away from zero, sign of delta
        function longint offset(longint f, longint delta);
            longint m;
            m = (f * mag(delta) + (longint'(1) << 23)) >>> 24;
            return delta < 0 ? -m : m;
        endfunction

        function void note_word(logic [1:0] kind, t_coord px, t_coord py);
            t_seg_word w;
            longint d01;
            longint d12;
            longint s;
            longint fa;
            longint fb;
            longint t16;
            w = '0;
            if (kind == REQ_DOWN) begin
                pts_x[0] = px;
                pts_y[0] = py;
                held = 1;
                moved = 0;
            end else if (kind == REQ_MOVE) begin
                moved = 1;
                if (held < 2) begin
                    pts_x[held] = px;
                    pts_y[held] = py;
                    held++;
                end else begin
                    d01 = point_dist(pts_x[0], pts_y[0], pts_x[1], pts_y[1]);
                    d12 = point_dist(pts_x[1], pts_y[1], px, py);
                    s = d01 + d12;
                    w.kind = RES_CURVE;
                    w.c1x = t_coord'(pts_x[1]);
                    w.c1y = t_coord'(pts_y[1]);
                    w.c2x = t_coord'(pts_x[1]);
                    w.c2y = t_coord'(pts_y[1]);
                    if (s != 0) begin
                        t16 = longint'(tension_q) << 16;
                        fa = (t16 * d01 + s / 2) / s;
                        fb = (t16 * d12 + s / 2) / s;
                        w.c1x = t_coord'(sat(pts_x[1] - offset(fa, px - pts_x[0])));
                        w.c1y = t_coord'(sat(pts_y[1] - offset(fa, py - pts_y[0])));
                        w.c2x = t_coord'(sat(pts_x[1] + offset(fb, px - pts_x[0])));
                        w.c2y = t_coord'(sat(pts_y[1] + offset(fb, py - pts_y[0])));
                    end
                    w.ex = px;
                    w.ey = py;
                    pending = {pending, w};
                    held = 0;
                end
            end else if (kind == REQ_UP) begin
                if (!moved) begin
                    w.kind = RES_DOT;
                    w.ex = px;
                    w.ey = py;
                    pending = {pending, w};
                end
                held = 0;
                moved = 0;
            end
        endfunction

        function void check_word(t_seg_word got);
            t_seg_word exp_w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.kind == RES_CURVE) segments++;
            else dots++;
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", exp_w, got);
            end
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_in_valid = 0;
    logic             o_in_stall;
    logic [1:0]       i_req_type = REQ_DOWN;
    t_coord           i_point_x = '0;
    t_coord           i_point_y = '0;
    logic             o_out_valid;
    logic             i_out_stall = 0;
    logic             o_result_kind;
    t_coord           o_ctrl1_x, o_ctrl1_y, o_ctrl2_x, o_ctrl2_y, o_end_x, o_end_y;
    logic             i_cfg_valid = 0;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_tension = '0;

    t_stroke_scoreboard sb;
    int  cycle_count = 0;
    int  words_sent = 0;
    bit  calm = 0;       // no idling on either side
    int  hold_off = 0;   // long receiver hold-off, counted down below

    stroke_spline_control_points_unit #(.COORD_BITS(CB)) u_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("stroke_spline_control_points_unit_tb: errors");
            $finish;
        end
    end

    // Receiver: random stall, long hold-off on request, check accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word({o_result_kind, o_ctrl1_x, o_ctrl1_y, o_ctrl2_x, o_ctrl2_y,
                           o_end_x, o_end_y});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 11);
        end
    end

    // Offer one word; hold it until accepted
    task automatic send_word(logic [1:0] kind, t_coord px, t_coord py);
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_req_type <= kind;
        i_point_x <= px;
        i_point_y <= py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(kind, px, py);
        words_sent++;
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_in_valid <= 0;
        while (sb.pending.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tension(logic [7:0] t);
        drain();
        i_cfg_valid <= 1;
        i_cfg_tension <= t;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sb.tension_q = t;
    endtask

    function automatic t_coord rnd_coord(int span_sel);
        if (span_sel == 0) return t_coord'($urandom);
        return t_coord'($signed($urandom_range(2000)) - 1000);
    endfunction

    // Well-formed stroke with random content
    task automatic stroke(int n_moves, bit up_end);
        int sel;
        sel = $urandom_range(3);
        send_word(REQ_DOWN, rnd_coord(sel), rnd_coord(sel));
        repeat (n_moves) send_word(REQ_MOVE, rnd_coord(sel), rnd_coord(sel));
        if (up_end) send_word(REQ_UP, rnd_coord(sel), rnd_coord(sel));
    endtask

    initial begin
        t_coord mx;
        t_coord mn;
        sb = new();
        mx = t_coord'((1 << (CB - 1)) - 1);
        mn = t_coord'(-(1 << (CB - 1)));
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, dots, zero distances, saturation, move without down
        send_word(REQ_MOVE, 16, 16);
        send_word(REQ_MOVE, 32, -16);
        send_word(REQ_MOVE, 100, 40);
        send_word(REQ_DOWN, mn, mn);
        send_word(REQ_UP, mx, mn);
        send_word(REQ_DOWN, 5, 5);
        send_word(REQ_MOVE, 5, 5);
        send_word(REQ_MOVE, 5, 5);
        send_word(REQ_UP, 0, 0);
        send_word(REQ_DOWN, mn, mn);
        send_word(REQ_MOVE, mx, mx);
        send_word(REQ_MOVE, mn, mn);
        send_word(REQ_DOWN, mn, mx);
        send_word(REQ_MOVE, mx, mn);
        send_word(REQ_MOVE, mn, mx);
        send_word(2'd3, mx, mx);
        send_word(REQ_UP, -1, -1);
        send_word(REQ_UP, 1, 1);
        write_tension(8'd255);
        send_word(REQ_DOWN, -2000, 0);
        send_word(REQ_MOVE, mx - 10, 300);
        send_word(REQ_MOVE, mn, -300);
        write_tension(8'd0);
        stroke(2, 1);

        // Random: mostly well-formed strokes, tension swept, some noise
        for (int ph = 0; ph < 4; ph++) begin
            write_tension(ph == 3 ? 8'd128 : 8'($urandom));
            calm = (ph == 1);
            if (ph == 2) begin
                hold_off = 600;
                for (int k = 0; k < 10; k++) stroke(2, 0);
            end
            while (words_sent < 25 + 110 * (ph + 1)) begin
                case ($urandom_range(9))
                    0: send_word(2'($urandom), rnd_coord(0), rnd_coord(0));
                    1: stroke(0, 1);
                    2: stroke($urandom_range(1, 3), 1);
                    default: stroke(2 * $urandom_range(1, 3), $urandom_range(1));
                endcase
            end
        end
        calm = 0;
        drain();

        $display("covered %0d input words: %0d curve segments, %0d dot markers",
                 words_sent, sb.segments, sb.dots);
        $display("tension swept over 0, 255, random values and reset value");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("stroke_spline_control_points_unit_tb: clean");
        end else begin
            $display("stroke_spline_control_points_unit_tb: errors");
        end
        $finish;
    end
endmodule
